// ===== rtl/core/scrambled_status_frame_receiver_defines.svh =====
// Assertion macros used by the scrambled status frame receiver port checker.
`ifndef SCRAMBLED_STATUS_FRAME_RECEIVER_DEFINES_SVH
`define SCRAMBLED_STATUS_FRAME_RECEIVER_DEFINES_SVH

// Implication in the same cycle, ignored while reset is high.
`define SSFR_ASSERT_IMPLY(name, cond, expr) \
  name: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
    else $error("%m: assertion failed");

// Implication in the next cycle, ignored while reset is high.
`define SSFR_ASSERT_NEXT(name, cond, expr) \
  name: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
    else $error("%m: assertion failed");

// Implication in the next cycle that also holds across reset.
`define SSFR_ASSERT_NEXT_ALWAYS(name, cond, expr) \
  name: assert property (@(posedge clk) (cond) |=> (expr)) \
    else $error("%m: assertion failed");

`endif

// ===== rtl/core/ssfr_pkg.sv =====
// Constants and types for the scrambled status frame receiver.
`default_nettype none

package ssfr_pkg;

  typedef logic [7:0] byte_t;
  typedef logic [1:0] kind_t;

  localparam byte_t HDR_BYTE   = 8'hAA;
  localparam byte_t SUM_BASE   = 8'h5A;
  localparam byte_t TYPE_STAT  = 8'hF1;
  localparam byte_t TYPE_CNT   = 8'hF2;
  localparam byte_t STAT_MASK  = 8'h3F;
  localparam byte_t KEY_RELOAD = 8'hAB;
  localparam byte_t MASK_RESET = 8'h19;

  localparam kind_t KIND_STATUS  = 2'd0;
  localparam kind_t KIND_COUNT   = 2'd1;
  localparam kind_t KIND_BADSUM  = 2'd2;
  localparam kind_t KIND_UNKNOWN = 2'd3;

  // Index of the check byte within a frame.
  localparam logic [2:0] CHECK_INDEX = 3'd4;

  // Register index of xor_mask, decoded from paddr[2].
  localparam logic REG_XOR_MASK = 1'b0;

endpackage

`default_nettype wire

// ===== rtl/core/scrambled_status_frame_receiver.sv =====
// Top level of the scrambled status frame receiver.
//
//   channel   direction  handshake             payload
//   in        sink       in_valid / in_stall   mode, rx_byte
//   out       source     out_valid / out_stall frame_kind, status_bits, count_value, new_key
//   cfg       APB slave  psel/penable/pwrite   paddr, pwdata, prdata
//
// One byte per cycle is taken while in_stall is low; a check byte is held in the input
// register, then its result is registered in the result register.
// The descramble key and frame state feed back through one register, which sets that rate.
// A stall on the output holds the result register and backs up into the input register.
// Reset clears the key, the frame state and both valid flags and loads xor_mask with 0x19.
`default_nettype none

module scrambled_status_frame_receiver (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [2:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 mode,
  input  ssfr_pkg::byte_t      rx_byte,
  output logic                 out_valid,
  input  logic                 out_stall,
  output ssfr_pkg::kind_t      frame_kind,
  output logic [5:0]           status_bits,
  output logic [8:0]           count_value,
  output ssfr_pkg::byte_t      new_key
);

  import ssfr_pkg::*;

  byte_t      xor_mask;
  logic       hold_valid;
  logic       hold_mode;
  byte_t      hold_byte;
  byte_t      descramble_key;
  logic       in_frame;
  logic [2:0] byte_index;
  byte_t      frame_bytes [4];

  logic       out_free;
  logic       step;
  byte_t      plain_byte;
  byte_t      byte_sum;
  byte_t      check_value;
  byte_t      key_next;
  logic       in_frame_next;
  logic [2:0] byte_index_next;
  logic       result_fire;
  kind_t      kind_next;
  logic [5:0] status_next;
  logic [8:0] count_next;

  // Configuration port.
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_XOR_MASK) ? {24'd0, xor_mask} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      xor_mask <= MASK_RESET;
    end else if (psel && penable && pwrite && (paddr[2] == REG_XOR_MASK)) begin
      xor_mask <= pwdata[7:0];
    end
  end

  // The result register is free when empty or being drained this cycle.
  assign out_free = !out_valid || !out_stall;
  assign step     = hold_valid && out_free;
  assign in_stall = hold_valid && !out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (!in_stall) begin
      hold_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      hold_mode <= mode;
      hold_byte <= rx_byte;
    end
  end

  assign plain_byte  = (hold_byte ^ xor_mask) - descramble_key;
  assign byte_sum    = frame_bytes[0] + frame_bytes[1] + frame_bytes[2] + frame_bytes[3];
  assign check_value = SUM_BASE - byte_sum;

  always_comb begin
    key_next        = descramble_key;
    in_frame_next   = in_frame;
    byte_index_next = byte_index;
    result_fire     = 1'b0;
    kind_next       = KIND_BADSUM;
    status_next     = 6'd0;
    count_next      = 9'd0;
    if (hold_mode) begin
      key_next        = KEY_RELOAD;
      in_frame_next   = 1'b0;
      byte_index_next = 3'd0;
    end else if (!in_frame) begin
      if (plain_byte == HDR_BYTE) begin
        in_frame_next   = 1'b1;
        byte_index_next = 3'd1;
      end
    end else if (byte_index < CHECK_INDEX) begin
      byte_index_next = byte_index + 3'd1;
    end else begin
      // Check byte: the frame ends here whatever its contents.
      in_frame_next   = 1'b0;
      byte_index_next = 3'd0;
      result_fire     = 1'b1;
      if (plain_byte == check_value) begin
        if (frame_bytes[1] == TYPE_STAT) begin
          kind_next   = KIND_STATUS;
          key_next    = frame_bytes[2];
          status_next = 6'(frame_bytes[3] & STAT_MASK);
        end else if (frame_bytes[1] == TYPE_CNT) begin
          kind_next   = KIND_COUNT;
          key_next    = frame_bytes[2];
          status_next = 6'(frame_bytes[3] & STAT_MASK);
          count_next  = {1'b0, frame_bytes[3]} + 9'd1;
        end else begin
          kind_next = KIND_UNKNOWN;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      descramble_key <= 8'd0;
      in_frame       <= 1'b0;
      byte_index     <= 3'd0;
    end else if (step) begin
      descramble_key <= key_next;
      in_frame       <= in_frame_next;
      byte_index     <= byte_index_next;
    end
  end

  always_ff @(posedge clk) begin
    if (step && !hold_mode) begin
      if (!in_frame && (plain_byte == HDR_BYTE)) begin
        frame_bytes[0] <= plain_byte;
      end else if (in_frame && (byte_index < CHECK_INDEX)) begin
        frame_bytes[byte_index[1:0]] <= plain_byte;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step) begin
      out_valid <= result_fire;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step && result_fire) begin
      frame_kind  <= kind_next;
      status_bits <= status_next;
      count_value <= count_next;
      new_key     <= key_next;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/ssfr_checker.sv =====
// Port-level checker for the scrambled status frame receiver, with its bind.
`default_nettype none

`include "scrambled_status_frame_receiver_defines.svh"

module ssfr_checker (
  input logic                 clk,
  input logic                 rst,
  input logic                 out_valid,
  input logic                 out_stall,
  input ssfr_pkg::kind_t      frame_kind,
  input logic [5:0]           status_bits,
  input logic [8:0]           count_value,
  input ssfr_pkg::byte_t      new_key
);

  import ssfr_pkg::*;

  logic [24:0] out_payload;
  logic        is_count;
  logic        has_count;
  logic        out_rejected;

  assign out_payload  = {frame_kind, status_bits, count_value, new_key};
  assign is_count     = (frame_kind == KIND_COUNT);
  assign has_count    = (count_value != 9'd0);
  assign out_rejected = (frame_kind == KIND_BADSUM) || (frame_kind == KIND_UNKNOWN);

  // No result survives a reset.
  `SSFR_ASSERT_NEXT_ALWAYS(a_reset_clears_out, rst, !out_valid)

  // A stalled result transaction holds its payload.
  `SSFR_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_payload))

  // Only count frames report a count, and they always report a nonzero one.
  `SSFR_ASSERT_IMPLY(a_count_kind, out_valid, is_count == has_count)

  // Rejected frames carry no status bits.
  `SSFR_ASSERT_IMPLY(a_bad_no_status, out_valid && out_rejected, status_bits == 6'd0)

endmodule

bind scrambled_status_frame_receiver ssfr_checker u_ssfr_checker (
  .clk         (clk),
  .rst         (rst),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .frame_kind  (frame_kind),
  .status_bits (status_bits),
  .count_value (count_value),
  .new_key     (new_key)
);

`default_nettype wire

// ===== tb/sv/scrambled_status_frame_receiver_checker.sv =====
// Checker for the scrambled status frame receiver: predicts frame reports and compares them.
module scrambled_status_frame_receiver_checker
  import ssfr_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic        pready,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic        mode,
  input  byte_t       rx_byte,
  input  logic        out_valid,
  input  logic        out_stall,
  input  kind_t       frame_kind,
  input  logic [5:0]  status_bits,
  input  logic [8:0]  count_value,
  input  byte_t       new_key,
  output int          errors,
  output int          pending
);

  typedef struct packed {
    kind_t       kind;
    logic [5:0]  status;
    logic [8:0]  count;
    byte_t       key;
  } frame_report_t;

  byte_t         mask_copy;
  byte_t         key_copy;
  logic          collecting;
  logic [2:0]    frame_pos;
  byte_t         frame_held [4];
  frame_report_t frame_reports_due [$];
  int            mismatches = 0;

  initial begin
    errors = 0;
    pending = 0;
  end

  // Descrambles one byte and advances the frame state; returns 1 when a frame ends.
  function automatic bit descramble_and_frame(input logic reload, input byte_t raw,
                                              output frame_report_t rep);
    byte_t plain;
    byte_t sum;
    rep = '0;
    if (reload) begin
      key_copy = KEY_RELOAD;
      collecting = 1'b0;
      frame_pos = '0;
      return 1'b0;
    end
    plain = (raw ^ mask_copy) - key_copy;
    if (!collecting) begin
      if (plain == HDR_BYTE) begin
        frame_held[0] = plain;
        frame_pos = 3'd1;
        collecting = 1'b1;
      end
      return 1'b0;
    end
    if (frame_pos < CHECK_INDEX) begin
      frame_held[frame_pos[1:0]] = plain;
      frame_pos = frame_pos + 3'd1;
      return 1'b0;
    end
    // This byte is the check byte, so the frame is complete.
    collecting = 1'b0;
    frame_pos = '0;
    sum = frame_held[0] + frame_held[1] + frame_held[2] + frame_held[3];
    rep.kind = KIND_BADSUM;
    if (plain == byte_t'(SUM_BASE - sum)) begin
      if (frame_held[1] == TYPE_STAT || frame_held[1] == TYPE_CNT) begin
        key_copy = frame_held[2];
        rep.status = frame_held[3][5:0];
        if (frame_held[1] == TYPE_CNT) begin
          rep.kind = KIND_COUNT;
          rep.count = {1'b0, frame_held[3]} + 9'd1;
        end else begin
          rep.kind = KIND_STATUS;
        end
      end else begin
        rep.kind = KIND_UNKNOWN;
      end
    end
    rep.key = key_copy;
    return 1'b1;
  endfunction

  always @(posedge clk) begin
    frame_report_t want;
    frame_report_t got;
    if (rst) begin
      mask_copy = MASK_RESET;
      key_copy = '0;
      collecting = 1'b0;
      frame_pos = '0;
      frame_reports_due.delete();
    end else begin
      if (out_valid && !out_stall) begin
        got = '{frame_kind, status_bits, count_value, new_key};
        if (frame_reports_due.size() == 0) begin
          if (mismatches < 10)
            $display("unexpected frame report: kind %0d status %h count %0d key %h",
                     got.kind, got.status, got.count, got.key);
          mismatches++;
        end else begin
          want = frame_reports_due.pop_front();
          if (got.kind !== want.kind || got.status !== want.status ||
              got.count !== want.count || got.key !== want.key) begin
            if (mismatches < 10)
              $display("frame report mismatch (expected/actual): kind %0d/%0d status %h/%h %s",
                       want.kind, got.kind, want.status, got.status,
                       $sformatf("count %0d/%0d key %h/%h",
                                 want.count, got.count, want.key, got.key));
            mismatches++;
          end
        end
      end
      if (psel && penable && pwrite && pready && paddr[2] == REG_XOR_MASK)
        mask_copy = pwdata[7:0];
      if (in_valid && !in_stall && descramble_and_frame(mode, rx_byte, want))
        frame_reports_due.push_back(want);
    end
    errors <= mismatches;
    pending <= frame_reports_due.size();
  end

endmodule

// ===== tb/sv/scrambled_status_frame_receiver_tb.sv =====
// Testbench top: drives frames and key reloads into the receiver and reports the verdict.
module scrambled_status_frame_receiver_tb;
  import ssfr_pkg::*;

  localparam int QUIET_LIMIT = 2000;
  localparam int PHASE_ITEMS = 70;
  localparam int PHASES = 6;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        mode = 1'b0;
  byte_t       rx_byte = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  kind_t       frame_kind;
  logic [5:0]  status_bits;
  logic [8:0]  count_value;
  byte_t       new_key;
  int          errors;
  int          pending;

  int quiet_cycles = 0;
  int stall_left = 0;
  int gap_pct = 20;
  int stall_pct = 30;
  bit calm = 1'b0;

  // Sender-side view of the line: key and mask in force, and whether the
  // receiver is known to be hunting with that key.
  byte_t line_key;
  byte_t line_mask;
  bit    in_step;
  int    items_sent = 0;

  scrambled_status_frame_receiver DUT (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .in_valid(in_valid), .in_stall(in_stall), .mode(mode), .rx_byte(rx_byte),
    .out_valid(out_valid), .out_stall(out_stall), .frame_kind(frame_kind),
    .status_bits(status_bits), .count_value(count_value), .new_key(new_key)
  );

  scrambled_status_frame_receiver_checker checker_i (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
    .paddr(paddr), .pwdata(pwdata),
    .in_valid(in_valid), .in_stall(in_stall), .mode(mode), .rx_byte(rx_byte),
    .out_valid(out_valid), .out_stall(out_stall), .frame_kind(frame_kind),
    .status_bits(status_bits), .count_value(count_value), .new_key(new_key),
    .errors(errors), .pending(pending)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst || calm) begin
      out_stall <= 1'b0;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 99) < stall_pct) begin
      out_stall <= 1'b1;
      stall_left <= $urandom_range(0, 9);
    end else begin
      out_stall <= 1'b0;
      stall_left <= $urandom_range(0, 19);
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) || (psel && penable)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("scrambled_status_frame_receiver_tb NOT OK");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send(input logic m, input byte_t raw);
    if (!calm && $urandom_range(0, 99) < gap_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    in_valid <= 1'b1;
    mode <= m;
    rx_byte <= raw;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
  endtask

  task automatic send_plain(input byte_t plain);
    byte_t r;
    r = plain + line_key;
    send(1'b0, r ^ line_mask);
  endtask

  task automatic reload_key();
    send(1'b1, byte_t'($urandom_range(0, 255)));
    line_key = KEY_RELOAD;
    in_step = 1'b1;
  endtask

  // Sends the first nbytes of a frame; a bad frame gets a corrupted check byte.
  task automatic send_frame(input byte_t kind_b, input byte_t k2, input byte_t b3,
                            input bit bad, input int nbytes);
    byte_t body [5];
    body[0] = HDR_BYTE;
    body[1] = kind_b;
    body[2] = k2;
    body[3] = b3;
    body[4] = SUM_BASE - (HDR_BYTE + kind_b + k2 + b3);
    if (bad) body[4] = body[4] ^ byte_t'($urandom_range(1, 255));
    for (int i = 0; i < nbytes; i++) send_plain(body[i]);
    if (nbytes < 5) in_step = 1'b0;
    else if (!bad && (kind_b == TYPE_STAT || kind_b == TYPE_CNT)) line_key = k2;
  endtask

  task automatic settle(input int tail);
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4 + tail) @(posedge clk);
  endtask

  task automatic write_mask(input byte_t v);
    settle(0);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= {REG_XOR_MASK, 2'b00};
    pwdata <= {24'd0, v};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    line_mask = v;
  endtask

  function automatic byte_t pick_byte();
    case ($urandom_range(0, 9))
      0: return 8'h00;
      1: return 8'hFF;
      default: return byte_t'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic byte_t good_type();
    return ($urandom_range(0, 1) != 0) ? TYPE_STAT : TYPE_CNT;
  endfunction

  task automatic random_sequence();
    int r;
    byte_t t;
    r = $urandom_range(0, 99);
    if (!in_step || r < 4) begin
      reload_key();
    end else if (r < 64) begin
      send_frame(good_type(), pick_byte(), pick_byte(), 1'b0, 5);
    end else if (r < 72) begin
      t = ($urandom_range(0, 3) == 0) ? byte_t'($urandom_range(0, 255)) : good_type();
      send_frame(t, pick_byte(), pick_byte(), 1'b1, 5);
    end else if (r < 80) begin
      send_frame(byte_t'($urandom_range(0, 255)), pick_byte(), pick_byte(), 1'b0, 5);
    end else if (r < 86) begin
      // A byte that cannot pass for a header keeps the receiver hunting.
      t = byte_t'($urandom_range(0, 255));
      if (t == HDR_BYTE) t = ~t;
      send_plain(t);
    end else if (r < 91) begin
      send_frame(good_type(), pick_byte(), pick_byte(), 1'b0, $urandom_range(1, 4));
    end else if (r < 97) begin
      repeat ($urandom_range(1, 5)) send(1'b0, byte_t'($urandom_range(0, 255)));
      in_step = 1'b0;
    end else if (!calm) begin
      settle(0);
    end
  endtask

  initial begin
    int stop_at;
    line_key = '0;
    line_mask = MASK_RESET;
    in_step = 1'b1;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part, run with the mask left by reset and begun with the key left by reset.
    send_plain(8'h00);
    send(1'b1, 8'hFF);
    line_key = KEY_RELOAD;
    send_frame(TYPE_CNT, 8'h00, 8'hFF, 1'b0, 5);
    send_frame(TYPE_STAT, 8'hFF, 8'h00, 1'b0, 5);
    send_frame(TYPE_STAT, 8'h12, 8'h55, 1'b1, 5);
    send_frame(8'h00, 8'h34, 8'hC0, 1'b0, 5);
    send_frame(TYPE_CNT, 8'h56, 8'h78, 1'b0, 2);
    send(1'b1, 8'h00);
    line_key = KEY_RELOAD;
    in_step = 1'b1;

    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: write_mask(8'h00);
        1: write_mask(8'hFF);
        default: write_mask(byte_t'($urandom_range(0, 255)));
      endcase
      calm = (ph == PHASES - 1);
      gap_pct = (ph == 2) ? 0 : $urandom_range(10, 40);
      stall_pct = (ph == 3) ? 0 : $urandom_range(20, 60);
      stop_at = items_sent + PHASE_ITEMS;
      while (items_sent < stop_at) random_sequence();
    end

    settle(8);
    if (errors == 0) begin
      $display("scrambled_status_frame_receiver_tb OK");
    end else begin
      $display("scrambled_status_frame_receiver_tb NOT OK");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+rtl/core
rtl/core/ssfr_pkg.sv
rtl/core/scrambled_status_frame_receiver.sv
rtl/core/ssfr_checker.sv
tb/sv/scrambled_status_frame_receiver_checker.sv
tb/sv/scrambled_status_frame_receiver_tb.sv
